// File: rtl/core/mpurb_pkg.sv
// ============================================================================
// mpurb_pkg
// Shared types and constants for the multi-port UART ring buffers.
// ============================================================================
package mpurb_pkg;

    localparam int OP_W    = 3;
    localparam int PORT_W  = 2;
    localparam int DATA_W  = 8;
    localparam int RXCNT_W = 6;
    localparam int TXCNT_W = 7;

    typedef enum logic [OP_W-1:0] {
        OP_RX_STORE = 3'd0,
        OP_RX_READ  = 3'd1,
        OP_TX_WRITE = 3'd2,
        OP_TX_DRAIN = 3'd3,
        OP_RX_PEEK  = 3'd4
    } t_op;

    // Where the result byte comes from
    typedef enum logic [1:0] {
        SRC_NONE = 2'd0,
        SRC_RX   = 2'd1,
        SRC_TX   = 2'd2
    } t_src;

    typedef struct packed {
        logic rx_we;
        logic rx_re;
        logic tx_we;
        logic tx_re;
    } t_mem_ctl;

    typedef struct packed {
        logic done;
        logic data_valid;
        t_src src;
    } t_rsp;

endpackage

// File: rtl/core/multi_port_uart_ring_buffers.sv
// ============================================================================
// multi_port_uart_ring_buffers
// Receive and transmit byte rings for several UART ports, one operation per
// word, with the ring bytes held in two synchronous RAMs.
// ============================================================================
//
//  Channel   Ports                                          Timing
//  -------   --------------------------------------------   -------------------
//  command   i_start, o_busy, i_op, i_port, i_data_in       taken on start & !busy
//  result    o_done, o_data_out, o_data_valid,              one-cycle strobe,
//            o_rx_available, o_tx_used, o_tx_active         no back-pressure
//
//  A command word is taken every cycle; its result appears on the cycle right
//  after it is taken. That delay comes from the registered read of the
//  byte RAMs; pointers live in flops and update at the accepting edge.
//  o_busy stays low: a word read in the cycle after a write sees the new byte.
//  Reset clears all pointers and transmit-active flags at once; ring contents
//  are left as they are and are only meaningful once written.
//  Results cannot be stalled; the receiver must take every o_done strobe.
//
module multi_port_uart_ring_buffers #(
    parameter int PORTS    = 4,
    parameter int RX_DEPTH = 64,
    parameter int TX_DEPTH = 128
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    output logic                          o_busy,
    input  logic [mpurb_pkg::OP_W-1:0]    i_op,
    input  logic [mpurb_pkg::PORT_W-1:0]  i_port,
    input  logic [mpurb_pkg::DATA_W-1:0]  i_data_in,
    output logic                          o_done,
    output logic [mpurb_pkg::DATA_W-1:0]  o_data_out,
    output logic                          o_data_valid,
    output logic [mpurb_pkg::RXCNT_W-1:0] o_rx_available,
    output logic [mpurb_pkg::TXCNT_W-1:0] o_tx_used,
    output logic                          o_tx_active
);
    import mpurb_pkg::*;

    localparam int PIW = (PORTS > 1) ? $clog2(PORTS) : 1;
    localparam int RAW = $clog2(RX_DEPTH);
    localparam int TAW = $clog2(TX_DEPTH);

    // Ring RAMs are addressed {port, pointer}
    localparam int RX_RAM_DEPTH = 2 ** (PIW + RAW);
    localparam int TX_RAM_DEPTH = 2 ** (PIW + TAW);

    logic               accept;
    t_mem_ctl           mem;
    t_rsp               rsp;
    logic [PIW+RAW-1:0] rx_addr;
    logic [PIW+TAW-1:0] tx_addr;
    logic [DATA_W-1:0]  rx_rdata;
    logic [DATA_W-1:0]  tx_rdata;

    // Never stall the command side
    assign o_busy = 1'b0;
    assign accept = i_start && !o_busy;

    mpurb_ctrl #(
        .PORTS    (PORTS),
        .RX_DEPTH (RX_DEPTH),
        .TX_DEPTH (TX_DEPTH)
    ) u_ctrl (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_accept       (accept),
        .i_op           (i_op),
        .i_port         (i_port),
        .o_mem          (mem),
        .o_rx_addr      (rx_addr),
        .o_tx_addr      (tx_addr),
        .o_rsp          (rsp),
        .o_rx_available (o_rx_available),
        .o_tx_used      (o_tx_used),
        .o_tx_active    (o_tx_active)
    );

    mpurb_ram #(
        .WIDTH (DATA_W),
        .DEPTH (RX_RAM_DEPTH)
    ) u_rx_ram (
        .i_clk   (i_clk),
        .i_we    (mem.rx_we),
        .i_re    (mem.rx_re),
        .i_addr  (rx_addr),
        .i_wdata (i_data_in),
        .o_rdata (rx_rdata)
    );

    mpurb_ram #(
        .WIDTH (DATA_W),
        .DEPTH (TX_RAM_DEPTH)
    ) u_tx_ram (
        .i_clk   (i_clk),
        .i_we    (mem.tx_we),
        .i_re    (mem.tx_re),
        .i_addr  (tx_addr),
        .i_wdata (i_data_in),
        .o_rdata (tx_rdata)
    );

    // Steer the RAM read data onto the result; drop it to zero otherwise
    always_comb begin
        case (rsp.src)
            SRC_RX:  o_data_out = rx_rdata;
            SRC_TX:  o_data_out = tx_rdata;
            default: o_data_out = '0;
        endcase
    end

    assign o_done       = rsp.done;
    assign o_data_valid = rsp.data_valid;

endmodule

// File: rtl/core/mpurb_ram.sv
// ============================================================================
// mpurb_ram
// Generic single-port synchronous RAM with a registered read.
// ============================================================================
module mpurb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_addr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// File: rtl/core/mpurb_ctrl.sv
// ============================================================================
// mpurb_ctrl
// Per-port head/tail pointers and busy flags; issues at most one RAM access per word
// and registers the result status.
// ============================================================================
module mpurb_ctrl #(
    parameter int PORTS    = 4,
    parameter int RX_DEPTH = 64,
    parameter int TX_DEPTH = 128,
    localparam int PIW = (PORTS > 1) ? $clog2(PORTS) : 1,
    localparam int RAW = $clog2(RX_DEPTH),
    localparam int TAW = $clog2(TX_DEPTH)
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_accept,
    input  logic [mpurb_pkg::OP_W-1:0]    i_op,
    input  logic [mpurb_pkg::PORT_W-1:0]  i_port,
    output mpurb_pkg::t_mem_ctl           o_mem,
    output logic [PIW+RAW-1:0]            o_rx_addr,
    output logic [PIW+TAW-1:0]            o_tx_addr,
    output mpurb_pkg::t_rsp               o_rsp,
    output logic [mpurb_pkg::RXCNT_W-1:0] o_rx_available,
    output logic [mpurb_pkg::TXCNT_W-1:0] o_tx_used,
    output logic                          o_tx_active
);
    import mpurb_pkg::*;

    localparam logic [RAW-1:0] RX_LAST = RAW'(RX_DEPTH - 1);
    localparam logic [TAW-1:0] TX_LAST = TAW'(TX_DEPTH - 1);

    logic [RAW-1:0]   r_rx_head [PORTS];
    logic [RAW-1:0]   r_rx_tail [PORTS];
    logic [TAW-1:0]   r_tx_head [PORTS];
    logic [TAW-1:0]   r_tx_tail [PORTS];
    logic [PORTS-1:0] r_tx_busy;

    t_rsp                r_rsp,       n_rsp;
    logic [RXCNT_W-1:0]  r_rx_avail,  n_rx_avail;
    logic [TXCNT_W-1:0]  r_tx_used,   n_tx_used;
    logic                r_tx_act,    n_tx_act;

    logic [PIW-1:0] idx;
    logic           port_ok;
    logic           go;
    t_op            op_e;
    logic [RAW-1:0] rh, rt, rh_nx, rt_nx, n_rh, n_rt;
    logic [TAW-1:0] th, tt, th_nx, tt_nx, n_th, n_tt;
    logic           n_busy;
    logic [RAW:0]   rx_cnt;
    logic [TAW:0]   tx_cnt;
    t_mem_ctl       mem;
    logic [RAW-1:0] rx_ptr;
    logic [TAW-1:0] tx_ptr;

    assign idx     = PIW'(i_port);
    assign port_ok = int'(i_port) < PORTS;
    assign go      = i_accept && port_ok;
    assign op_e    = t_op'(i_op);

    assign rh    = r_rx_head[idx];
    assign rt    = r_rx_tail[idx];
    assign th    = r_tx_head[idx];
    assign tt    = r_tx_tail[idx];
    assign rh_nx = (rh == RX_LAST) ? '0 : rh + 1'b1;
    assign rt_nx = (rt == RX_LAST) ? '0 : rt + 1'b1;
    assign th_nx = (th == TX_LAST) ? '0 : th + 1'b1;
    assign tt_nx = (tt == TX_LAST) ? '0 : tt + 1'b1;

    always_comb begin
        n_rh   = rh;
        n_rt   = rt;
        n_th   = th;
        n_tt   = tt;
        n_busy = r_tx_busy[idx];
        mem    = '0;
        rx_ptr = rt;
        tx_ptr = tt_nx;
        n_rsp  = '0;
        if (go) begin
            n_rsp.done = 1'b1;
            unique case (op_e)
                OP_RX_STORE: begin
                    mem.rx_we = 1'b1;
                    rx_ptr    = rh;
                    n_rh      = rh_nx;
                end
                OP_RX_READ: begin
                    mem.rx_re = 1'b1;
                    n_rsp.src = SRC_RX;
                    if (rh != rt) begin
                        n_rt = rt_nx;
                    end
                end
                OP_TX_WRITE: begin
                    mem.tx_we = 1'b1;
                    tx_ptr    = th_nx;
                    n_th      = th_nx;
                    n_busy    = 1'b1;
                end
                OP_TX_DRAIN: begin
                    if (th != tt) begin
                        mem.tx_re        = 1'b1;
                        n_rsp.src        = SRC_TX;
                        n_rsp.data_valid = 1'b1;
                        n_tt             = tt_nx;
                    end
                    if (th == n_tt) begin
                        n_busy = 1'b0;
                    end
                end
                OP_RX_PEEK: begin
                    if (rh != rt) begin
                        mem.rx_re = 1'b1;
                        n_rsp.src = SRC_RX;
                    end
                end
                default: begin
                end
            endcase
        end else if (i_accept) begin
            n_rsp.done = 1'b1;
        end
    end

    // Counts after the step, modulo the ring depth
    assign rx_cnt = (n_rh >= n_rt) ? ({1'b0, n_rh} - {1'b0, n_rt})
                                   : ({1'b0, n_rh} + (RAW+1)'(RX_DEPTH) - {1'b0, n_rt});
    assign tx_cnt = (n_th >= n_tt) ? ({1'b0, n_th} - {1'b0, n_tt})
                                   : ({1'b0, n_th} + (TAW+1)'(TX_DEPTH) - {1'b0, n_tt});

    assign n_rx_avail = go ? RXCNT_W'(rx_cnt) : '0;
    assign n_tx_used  = go ? TXCNT_W'(tx_cnt) : '0;
    assign n_tx_act   = go ? n_busy : 1'b0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int p = 0; p < PORTS; p++) begin
                r_rx_head[p] <= '0;
                r_rx_tail[p] <= '0;
                r_tx_head[p] <= '0;
                r_tx_tail[p] <= '0;
            end
            r_tx_busy  <= '0;
            r_rsp      <= '0;
            r_rx_avail <= '0;
            r_tx_used  <= '0;
            r_tx_act   <= 1'b0;
        end else begin
            if (go) begin
                r_rx_head[idx] <= n_rh;
                r_rx_tail[idx] <= n_rt;
                r_tx_head[idx] <= n_th;
                r_tx_tail[idx] <= n_tt;
                r_tx_busy[idx] <= n_busy;
            end
            r_rsp      <= n_rsp;
            r_rx_avail <= n_rx_avail;
            r_tx_used  <= n_tx_used;
            r_tx_act   <= n_tx_act;
        end
    end

    assign o_mem          = mem;
    assign o_rx_addr      = {idx, rx_ptr};
    assign o_tx_addr      = {idx, tx_ptr};
    assign o_rsp          = r_rsp;
    assign o_rx_available = r_rx_avail;
    assign o_tx_used      = r_tx_used;
    assign o_tx_active    = r_tx_act;

endmodule

// File: rtl/core/mpurb_chk.sv
// ============================================================================
// mpurb_chk
// Port-level checks on the ring buffer block, bound to the top level.
// ============================================================================
module mpurb_chk #(
    parameter int PORTS = 4
) (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          i_start,
    input logic                          o_busy,
    input logic [mpurb_pkg::OP_W-1:0]    i_op,
    input logic [mpurb_pkg::PORT_W-1:0]  i_port,
    input logic                          o_done,
    input logic                          o_data_valid,
    input logic                          o_tx_active
);
    import mpurb_pkg::*;

    // Every taken word yields a strobe on the next cycle
    a_done_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_start && !o_busy) |=> o_done)
        else $error("result strobe missing after a taken word");

    // No strobe without a word taken the cycle before
    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(i_start && !o_busy))
        else $error("result strobe without a taken word");

    // A drained byte only comes from a drain command
    a_valid_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_data_valid |-> (o_done && $past(i_op) == OP_TX_DRAIN))
        else $error("data_valid without a drain");

    // Queuing a byte on a real port leaves the port transmit-active
    a_tx_active: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && $past(i_op) == OP_TX_WRITE && int'($past(i_port)) < PORTS)
        |-> o_tx_active)
        else $error("transmit-active flag not set after a queue");

endmodule

bind multi_port_uart_ring_buffers mpurb_chk #(
    .PORTS (PORTS)
) u_mpurb_chk (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_start      (i_start),
    .o_busy       (o_busy),
    .i_op         (i_op),
    .i_port       (i_port),
    .o_done       (o_done),
    .o_data_valid (o_data_valid),
    .o_tx_active  (o_tx_active)
);

// File: tb/tb.sv
// ----------------------------------------------------------------------------
// tb - self-checking bench for multi_port_uart_ring_buffers
// Drives command words (receive store, read and peek, transmit write and
// drain, unused codes) at random spacing, mirrors the per-port rings in a
// shadow copy and checks every result strobe field by field.
// ----------------------------------------------------------------------------
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import mpurb_pkg::*;

    localparam int PORTS     = 4;
    localparam int RX_DEPTH  = 64;
    localparam int TX_DEPTH  = 128;
    localparam int N_RANDOM  = 1600;
    localparam int MAX_GAP   = 9;
    localparam int TAIL_CYC  = 8;
    localparam logic [OP_W-1:0] OP_LAST = '1;

    // One command word waiting for the driver, with the idle cycles to hold before it
    typedef struct {
        logic [OP_W-1:0]   op;
        logic [PORT_W-1:0] port;
        logic [DATA_W-1:0] data;
        int                gap;
    } t_word;

    typedef struct packed {
        logic [DATA_W-1:0]  data_out;
        logic               data_valid;
        logic [RXCNT_W-1:0] rx_avail;
        logic [TXCNT_W-1:0] tx_used;
        logic               tx_active;
    } t_reply;

    logic                 i_clk     = 1'b0;
    logic                 i_rst_n   = 1'b0;
    logic                 i_start   = 1'b0;
    logic [OP_W-1:0]      i_op      = '0;
    logic [PORT_W-1:0]    i_port    = '0;
    logic [DATA_W-1:0]    i_data_in = '0;
    logic                 o_busy;
    logic                 o_done;
    logic [DATA_W-1:0]    o_data_out;
    logic                 o_data_valid;
    logic [RXCNT_W-1:0]   o_rx_available;
    logic [TXCNT_W-1:0]   o_tx_used;
    logic                 o_tx_active;

    multi_port_uart_ring_buffers #(
        .PORTS    (PORTS),
        .RX_DEPTH (RX_DEPTH),
        .TX_DEPTH (TX_DEPTH)
    ) u_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_start        (i_start),
        .o_busy         (o_busy),
        .i_op           (i_op),
        .i_port         (i_port),
        .i_data_in      (i_data_in),
        .o_done         (o_done),
        .o_data_out     (o_data_out),
        .o_data_valid   (o_data_valid),
        .o_rx_available (o_rx_available),
        .o_tx_used      (o_tx_used),
        .o_tx_active    (o_tx_active)
    );

    initial begin
        forever #2 i_clk = ~i_clk;
    end

    // Synchronous reset, asserted once only
    initial begin
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
    end

    // Give up long after the slowest legal run would have ended
    initial begin
        #400_000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // ------------------------------------------------------------------
    // Shadow rings. Depths equal 2**counter width, so the pointers wrap
    // by plain overflow, exactly like the hardware pointers.
    // ------------------------------------------------------------------
    logic [DATA_W-1:0]  rx_ring [PORTS][RX_DEPTH];
    logic [DATA_W-1:0]  tx_ring [PORTS][TX_DEPTH];
    logic [RXCNT_W-1:0] rx_hd   [PORTS] = '{default: '0};
    logic [RXCNT_W-1:0] rx_tl   [PORTS] = '{default: '0};
    logic [TXCNT_W-1:0] tx_hd   [PORTS] = '{default: '0};
    logic [TXCNT_W-1:0] tx_tl   [PORTS] = '{default: '0};
    logic               tx_act  [PORTS] = '{default: 1'b0};

    t_word  pend_q  [$];
    t_reply reply_q [$];
    int     err_cnt  = 0;
    int     idle_cnt = 0;

    // Bookkeeping for the generator: how full each receive ring will be and how
    // many bytes it has ever taken, so a read never lands on a never-written byte
    logic [RXCNT_W-1:0] plan_rx_cnt    [PORTS] = '{default: '0};
    int                 plan_rx_stores [PORTS] = '{default: 0};
    bit                 quiet = 1'b0;

    // Apply one word to the shadow rings and return the reply it must produce
    function automatic t_reply advance_rings(logic [OP_W-1:0] op, logic [PORT_W-1:0] port,
                                             logic [DATA_W-1:0] data);
        t_reply             rep;
        logic [TXCNT_W-1:0] nxt;
        rep = '0;
        if (int'(port) >= PORTS) return rep;
        case (op)
            OP_RX_STORE: begin
                // no full check: the head may run over the tail and lose data
                rx_ring[port][rx_hd[port]] = data;
                rx_hd[port] = rx_hd[port] + 1'b1;
            end
            OP_RX_READ: begin
                // an empty ring hands back the stale byte and keeps the tail
                rep.data_out = rx_ring[port][rx_tl[port]];
                if (rx_hd[port] != rx_tl[port]) rx_tl[port] = rx_tl[port] + 1'b1;
            end
            OP_TX_WRITE: begin
                // transmit head moves first, then takes the byte
                nxt = tx_hd[port] + 1'b1;
                tx_ring[port][nxt] = data;
                tx_hd[port] = nxt;
                tx_act[port] = 1'b1;
            end
            OP_TX_DRAIN: begin
                if (tx_hd[port] != tx_tl[port]) begin
                    nxt = tx_tl[port] + 1'b1;
                    rep.data_out   = tx_ring[port][nxt];
                    rep.data_valid = 1'b1;
                    tx_tl[port] = nxt;
                end
                if (tx_hd[port] == tx_tl[port]) tx_act[port] = 1'b0;
            end
            OP_RX_PEEK: begin
                if (rx_hd[port] != rx_tl[port]) rep.data_out = rx_ring[port][rx_tl[port]];
            end
            default: ;
        endcase
        rep.rx_avail  = rx_hd[port] - rx_tl[port];
        rep.tx_used   = tx_hd[port] - tx_tl[port];
        rep.tx_active = tx_act[port];
        return rep;
    endfunction

    task automatic check_field(string name, int unsigned want, int unsigned got);
        if (want != got) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            err_cnt++;
        end
    endtask

    // Queue one word. A receive read that would hit a never-written byte turns
    // into a peek, which touches nothing.
    function automatic void queue_word(logic [OP_W-1:0] op, logic [PORT_W-1:0] port,
                                       logic [DATA_W-1:0] data);
        t_word w;
        if (op == OP_RX_READ && plan_rx_cnt[port] == '0 && plan_rx_stores[port] < RX_DEPTH)
            op = OP_RX_PEEK;
        if (op == OP_RX_STORE) begin
            plan_rx_cnt[port] = plan_rx_cnt[port] + 1'b1;
            plan_rx_stores[port]++;
        end else if (op == OP_RX_READ && plan_rx_cnt[port] != '0) begin
            plan_rx_cnt[port] = plan_rx_cnt[port] - 1'b1;
        end
        w.op   = op;
        w.port = port;
        w.data = data;
        w.gap  = quiet ? 0 : $urandom_range(0, MAX_GAP);
        pend_q.push_back(w);
    endfunction

    function automatic logic [DATA_W-1:0] rand_byte();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return '1;
            default: return DATA_W'($urandom_range(0, 255));
        endcase
    endfunction

    function automatic logic [OP_W-1:0] pick_op();
        int r;
        r = $urandom_range(0, 99);
        if (r < 22) return OP_RX_STORE;
        if (r < 44) return OP_RX_READ;
        if (r < 64) return OP_TX_WRITE;
        if (r < 84) return OP_TX_DRAIN;
        if (r < 95) return OP_RX_PEEK;
        return OP_W'($urandom_range(int'(OP_RX_PEEK) + 1, int'(OP_LAST)));
    endfunction

    // ------------------------------------------------------------------
    // Driver: present the next word once the previous one is taken and its
    // idle cycles have passed. Each branch touches i_start once per edge.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin : p_driver
        t_word w;
        if (!i_rst_n) begin
            i_start  <= 1'b0;
            idle_cnt <= 0;
        end else if (!i_start || !o_busy) begin
            if (pend_q.size() == 0) begin
                i_start <= 1'b0;
            end else if (idle_cnt < pend_q[0].gap) begin
                i_start  <= 1'b0;
                idle_cnt <= idle_cnt + 1;
            end else begin
                w = pend_q.pop_front();
                i_op      <= w.op;
                i_port    <= w.port;
                i_data_in <= w.data;
                i_start   <= 1'b1;
                idle_cnt  <= 0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Monitor: predict on every accepted word, then check any result strobe
    // against the oldest prediction. Predicting first keeps this correct
    // whatever the latency turns out to be.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin : p_monitor
        t_reply want;
        if (i_rst_n) begin
            if (i_start && !o_busy) reply_q.push_back(advance_rings(i_op, i_port, i_data_in));
            if (o_done) begin
                if (reply_q.size() == 0) begin
                    $display("%0t: result with nothing expected, actual data_out %0d",
                             $time, o_data_out);
                    err_cnt++;
                end else begin
                    want = reply_q.pop_front();
                    check_field("data_out",     want.data_out,   o_data_out);
                    check_field("data_valid",   want.data_valid, o_data_valid);
                    check_field("rx_available", want.rx_avail,   o_rx_available);
                    check_field("tx_used",      want.tx_used,    o_tx_used);
                    check_field("tx_active",    want.tx_active,  o_tx_active);
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus, then the end of the run
    // ------------------------------------------------------------------
    initial begin : p_stim
        int n_rand;
        int len;
        int p;
        int k;
        logic [OP_W-1:0] op;

        // Directed: byte extremes through one receive ring, then read it dry
        queue_word(OP_RX_STORE, 0, 8'h00);
        queue_word(OP_RX_STORE, 0, 8'hFF);
        queue_word(OP_RX_STORE, 0, 8'hA5);
        queue_word(OP_RX_PEEK,  0, 8'h00);
        queue_word(OP_RX_READ,  0, 8'h00);
        queue_word(OP_RX_READ,  0, 8'h00);
        queue_word(OP_RX_PEEK,  0, 8'h00);
        queue_word(OP_RX_READ,  0, 8'h00);
        // peek on an empty ring, both on a used and an untouched port
        queue_word(OP_RX_PEEK,  0, 8'hFF);
        queue_word(OP_RX_PEEK,  1, 8'hFF);
        // drain on an empty transmit ring
        queue_word(OP_TX_DRAIN, 2, 8'hFF);
        // two transmit bytes; the second drain drops the flag, one more finds it empty
        queue_word(OP_TX_WRITE, 3, 8'hFF);
        queue_word(OP_TX_WRITE, 3, 8'h00);
        queue_word(OP_TX_DRAIN, 3, 8'h00);
        queue_word(OP_TX_DRAIN, 3, 8'h00);
        queue_word(OP_TX_DRAIN, 3, 8'h00);
        // leave a port with the flag set, then unused codes must change nothing
        queue_word(OP_TX_WRITE, 1, 8'h5A);
        for (op = OP_RX_PEEK + 1'b1; op != '0; op++) queue_word(op, 1, 8'hFF);
        queue_word(OP_LAST,     3, 8'h00);
        queue_word(OP_RX_STORE, 3, 8'h80);
        queue_word(OP_RX_READ,  3, 8'h7F);

        // Random part in segments: mixed traffic plus fill and drain bursts that
        // wrap and overrun the rings. Some segments run with no idle cycles.
        n_rand = 0;
        while (n_rand < N_RANDOM) begin
            quiet = ($urandom_range(0, 3) == 0);
            p     = $urandom_range(0, PORTS - 1);
            case ($urandom_range(0, 9))
                0, 1, 2, 3: begin
                    len = $urandom_range(20, 60);
                    for (k = 0; k < len; k++)
                        queue_word(pick_op(), PORT_W'($urandom_range(0, PORTS - 1)), rand_byte());
                end
                4: begin
                    len = $urandom_range(50, 80);
                    for (k = 0; k < len; k++) queue_word(OP_RX_STORE, PORT_W'(p), rand_byte());
                end
                5: begin
                    len = $urandom_range(10, 70);
                    for (k = 0; k < len; k++) queue_word(OP_RX_READ, PORT_W'(p), rand_byte());
                end
                6: begin
                    len = $urandom_range(100, 140);
                    for (k = 0; k < len; k++) queue_word(OP_TX_WRITE, PORT_W'(p), rand_byte());
                end
                7: begin
                    len = $urandom_range(10, 140);
                    for (k = 0; k < len; k++) queue_word(OP_TX_DRAIN, PORT_W'(p), rand_byte());
                end
                8: begin
                    len = $urandom_range(10, 30);
                    for (k = 0; k < len; k++)
                        queue_word(k[0] ? OP_RX_READ : OP_RX_PEEK, PORT_W'(p), rand_byte());
                end
                default: begin
                    len = $urandom_range(20, 40);
                    for (k = 0; k < len; k++) queue_word(pick_op(), PORT_W'(k % PORTS), rand_byte());
                end
            endcase
            n_rand += len;
        end

        // Hold until every word is taken and every result is back, then drain
        @(posedge i_rst_n);
        while (pend_q.size() != 0 || i_start) @(negedge i_clk);
        while (reply_q.size() != 0) @(negedge i_clk);
        repeat (TAIL_CYC) @(negedge i_clk);
        if (err_cnt == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

// File: sim.f
rtl/core/mpurb_pkg.sv
rtl/core/mpurb_ram.sv
rtl/core/mpurb_ctrl.sv
rtl/core/multi_port_uart_ring_buffers.sv
rtl/core/mpurb_chk.sv
tb/tb.sv
